### src/i2c_transfer_sequencer_assert.svh
// Assertion macros shared by the sequencer RTL.
// Included by the modules that carry concurrent assertions.
`ifndef I2C_TRANSFER_SEQUENCER_ASSERT_SVH
`define I2C_TRANSFER_SEQUENCER_ASSERT_SVH

// implication checked every clock, muted in reset
`define SEQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define SEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/its_pkg.sv
// Types and constants of the I2C transfer sequencer.
// No dependencies.
package its_pkg;

    localparam logic [2:0] K_LOAD  = 3'd0;
    localparam logic [2:0] K_START_WR = 3'd1;
    localparam logic [2:0] K_START_RD = 3'd2;
    localparam logic [2:0] K_TICK  = 3'd3;
    localparam logic [2:0] K_FETCH = 3'd4;
    localparam logic [2:0] K_ADDR  = 3'd5;

    localparam logic [2:0] O_STATUS = 3'd0;
    localparam logic [2:0] O_PUSH   = 3'd1;
    localparam logic [2:0] O_START  = 3'd2;
    localparam logic [2:0] O_RDATA  = 3'd3;
    localparam logic [2:0] O_ADDR   = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_LONG = 2'd2;
    localparam logic [1:0] ST_BADA = 2'd3;

    localparam logic [7:0] ADDR_BAD_BIT = 8'h80;
    localparam logic [7:0] ADDR_MASK    = 8'h7F;
    localparam int unsigned MAX_PUSH = 16;

    typedef enum logic [5:0] {
        PH_ENTRY  = 6'b000001,
        PH_READY  = 6'b000010,
        PH_TX     = 6'b000100,
        PH_WAIT   = 6'b001000,
        PH_RDPEND = 6'b010000,
        PH_RX     = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [2:0] kind;
        logic [4:0] index;
        logic [7:0] data_byte;
        logic [7:0] length;
        logic [4:0] tx_free;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       xfer_done;
        logic       xfer_error;
        logic       stretch_timeout;
        logic       tx_empty;
    } t_in_item;

    typedef struct packed {
        logic [2:0] out_kind;
        logic [1:0] status;
        logic [7:0] value;
        logic       start_is_read;
        logic [7:0] start_length;
        logic       ready_res;
        logic       last;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic       wr_load;     // write store write
        logic       rx_store;    // read store write at read_pos, advance
        logic       wr_reset;    // write_pos <= 0, write_count <= length
        logic       clear_all;   // ready entry clears counters
        logic       rd_set;      // read_pos <= 0, read_count <= length
        logic       push;        // emit write byte, advance write_pos
        logic       emit;        // emit result from fields below
        logic [2:0] kind;
        logic [1:0] status;
        logic       use_fetch;   // value from read store
        logic [7:0] value;
        logic       is_read;
        logic [7:0] slen;
        logic       ready_res;
        logic       last;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic wr_more;   // write_pos < write_count
        logic rd_more;   // read_pos < read_count
        logic busy;      // output register occupied
        logic [7:0] read_count;
    } t_sts;

endpackage

### src/its_datapath.sv
// Datapath: write and read stores, position counters, output register.
// Depends on its_pkg.
module its_datapath import its_pkg::*; #(
    parameter int WRITE_DEPTH = 32,
    parameter int READ_DEPTH  = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);
    localparam int WA = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;
    localparam int RA = (READ_DEPTH > 1) ? $clog2(READ_DEPTH) : 1;

    logic [7:0] r_wmem [WRITE_DEPTH];
    logic [7:0] r_rmem [READ_DEPTH];
    logic [7:0] r_write_pos, r_write_count, r_read_pos, r_read_count;
    logic [7:0] r_wdata, r_rdata;
    logic       r_valid, r_pend;
    t_cmd       r_cmd_q;
    t_out_item  r_out;
    logic       n_valid;
    logic [7:0] idx;

    assign idx = {3'd0, i_item.index};

    // store reads registered; the command and read data are registered before the result is formed
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_load && 32'(idx) < WRITE_DEPTH)
            r_wmem[idx[WA-1:0]] <= i_item.data_byte;
        if (i_cmd.rx_store && 32'(r_read_pos) < READ_DEPTH)
            r_rmem[r_read_pos[RA-1:0]] <= i_item.rx_byte;
        r_wdata <= (32'(r_write_pos) < WRITE_DEPTH) ? r_wmem[r_write_pos[WA-1:0]] : 8'd0;
        r_rdata <= (32'(idx) < READ_DEPTH) ? r_rmem[idx[RA-1:0]] : 8'd0;
        r_cmd_q <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_pos <= '0; r_write_count <= '0;
            r_read_pos <= '0; r_read_count <= '0;
            r_pend <= 1'b0;
        end else begin
            r_pend <= i_cmd.emit;
            if (i_cmd.clear_all) begin
                r_write_pos <= '0; r_write_count <= '0;
                r_read_pos <= '0; r_read_count <= '0;
            end
            if (i_cmd.wr_reset) begin
                r_write_pos <= '0;
                r_write_count <= i_item.length;
            end
            if (i_cmd.push) r_write_pos <= r_write_pos + 8'd1;
            if (i_cmd.rd_set) begin
                r_read_pos <= '0;
                r_read_count <= i_item.length;
            end
            if (i_cmd.rx_store) r_read_pos <= r_read_pos + 8'd1;
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (r_valid && !i_stall) n_valid = 1'b0;
        if (r_pend) n_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else r_valid <= n_valid;
    end

    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_out.out_kind      <= r_cmd_q.kind;
            r_out.status        <= r_cmd_q.status;
            r_out.value         <= r_cmd_q.push ? r_wdata :
                                   (r_cmd_q.use_fetch ? r_rdata : r_cmd_q.value);
            r_out.start_is_read <= r_cmd_q.is_read;
            r_out.start_length  <= r_cmd_q.slen;
            r_out.ready_res     <= r_cmd_q.ready_res;
            r_out.last          <= r_cmd_q.last;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_out;
    assign o_sts.wr_more = r_write_pos < r_write_count;
    assign o_sts.rd_more = r_read_pos < r_read_count;
    assign o_sts.busy = r_pend || (r_valid && i_stall);
    assign o_sts.read_count = r_read_count;

`include "i2c_transfer_sequencer_assert.svh"
    `SEQ_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, r_pend, !(r_valid && i_stall))
    `SEQ_ASSERT_IMP(a_push_has_data, i_clk, i_rst_n, i_cmd.push, r_write_pos < r_write_count)
    `SEQ_ASSERT_IMP(a_rx_in_range, i_clk, i_rst_n, i_cmd.rx_store, r_read_pos < r_read_count)
endmodule

### src/its_ctrl.sv
// Controller: phase machine and per-item result sequencing.
// Depends on its_pkg.
module its_ctrl import its_pkg::*; #(
    parameter int WRITE_DEPTH = 32,
    parameter int READ_DEPTH  = 32,
    parameter int FIFO_DEPTH  = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_item i_item,
    output t_in_item o_item,
    input  t_sts     i_sts,
    output t_cmd     o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PUSH  = 4'b0010,
        S_START = 4'b0100,
        S_FINAL = 4'b1000
    } t_step;

    localparam int LIM = (FIFO_DEPTH < MAX_PUSH) ? FIFO_DEPTH : MAX_PUSH;

    t_step      r_step, n_step;
    t_phase     r_phase, n_phase;
    logic       r_raw, n_raw;
    t_in_item   r_item;
    logic [4:0] r_room, n_room;
    logic       r_wr;      // item is start write (else tick)
    logic [1:0] r_fstat;
    t_cmd       n_cmd;
    logic       accept;
    logic [4:0] lim;

    assign o_stall = (r_step != S_IDLE) || i_sts.busy;
    assign accept  = i_valid && !o_stall;
    assign o_item  = accept ? i_item : r_item;
    assign lim = (32'(i_item.tx_free) > LIM) ? 5'(LIM) : i_item.tx_free;

    always_comb begin
        n_step = r_step; n_phase = r_phase; n_raw = r_raw; n_room = r_room;
        n_cmd = '0;
        n_cmd.ready_res = (r_phase == PH_READY);
        case (r_step)
            S_IDLE: if (accept) begin
                n_cmd.emit = 1'b1;
                n_cmd.last = 1'b1;
                n_cmd.kind = O_STATUS;
                case (i_item.kind)
                    K_LOAD: begin
                        if (32'(i_item.index) >= WRITE_DEPTH) n_cmd.status = ST_LONG;
                        else if (r_phase == PH_TX) n_cmd.status = ST_BUSY;
                        else n_cmd.wr_load = 1'b1;
                    end
                    K_START_WR: begin
                        if (32'(i_item.length) > WRITE_DEPTH) n_cmd.status = ST_LONG;
                        else if (r_phase != PH_READY) n_cmd.status = ST_BUSY;
                        else begin
                            n_cmd = '0;
                            n_cmd.wr_reset = 1'b1;
                            n_room = lim;
                            n_step = S_PUSH;
                        end
                    end
                    K_START_RD: begin
                        if (32'(i_item.length) > READ_DEPTH) n_cmd.status = ST_LONG;
                        else begin
                            n_cmd.rd_set = 1'b1;
                            if (r_phase == PH_TX || r_phase == PH_WAIT) n_raw = 1'b1;
                            else if (r_phase == PH_READY) begin
                                n_phase = PH_RX;
                                n_cmd.kind = O_START;
                                n_cmd.is_read = 1'b1;
                                n_cmd.slen = i_item.length;
                                n_cmd.last = 1'b0;
                                n_cmd.ready_res = 1'b0;
                                n_step = S_FINAL;
                            end else n_cmd.status = ST_BUSY;
                        end
                    end
                    K_TICK: begin
                        case (r_phase)
                            PH_ENTRY: begin
                                n_cmd.clear_all = 1'b1;
                                n_raw = 1'b0;
                                n_phase = PH_READY;
                            end
                            PH_TX: begin
                                n_cmd.emit = 1'b0;
                                n_room = lim;
                                n_step = S_PUSH;
                            end
                            PH_WAIT: begin
                                if (r_raw) n_phase = PH_RDPEND;
                                else if (i_item.xfer_done) n_phase = PH_ENTRY;
                            end
                            PH_RDPEND: begin
                                if (i_item.xfer_error || i_item.stretch_timeout) begin
                                    n_raw = 1'b0;
                                    n_phase = PH_WAIT;
                                end else if (i_item.tx_empty) begin
                                    n_phase = PH_RX;
                                    n_cmd.kind = O_START;
                                    n_cmd.is_read = 1'b1;
                                    n_cmd.slen = i_sts.read_count;
                                    n_cmd.last = 1'b0;
                                    n_step = S_FINAL;
                                end
                            end
                            PH_RX: begin
                                if (i_sts.rd_more && i_item.rx_valid) n_cmd.rx_store = 1'b1;
                                if (i_item.xfer_done) n_phase = PH_ENTRY;
                            end
                            default: ;
                        endcase
                        n_cmd.ready_res = (n_phase == PH_READY);
                    end
                    K_FETCH: begin
                        n_cmd.kind = O_RDATA;
                        if (32'(i_item.index) < READ_DEPTH) n_cmd.use_fetch = 1'b1;
                        else n_cmd.status = ST_LONG;
                    end
                    K_ADDR: begin
                        if ((i_item.data_byte & ADDR_BAD_BIT) != 8'd0) n_cmd.status = ST_BADA;
                        else begin
                            n_cmd.kind = O_ADDR;
                            n_cmd.value = i_item.data_byte & ADDR_MASK;
                        end
                    end
                    default: ;
                endcase
                if (n_step == S_FINAL && i_item.kind == K_START_RD)
                    n_cmd.ready_res = 1'b0;
            end
            S_PUSH: if (!i_sts.busy) begin
                if (i_sts.wr_more && r_room != 5'd0) begin
                    n_cmd.push = 1'b1;
                    n_cmd.emit = 1'b1;
                    n_cmd.kind = O_PUSH;
                    n_cmd.ready_res = 1'b0;
                    n_room = r_room - 5'd1;
                end else begin
                    if (r_wr) begin
                        n_phase = i_sts.wr_more ? PH_TX : PH_WAIT;
                        n_cmd.emit = 1'b1;
                        n_cmd.kind = O_START;
                        n_cmd.slen = r_item.length;
                        n_step = S_FINAL;
                    end else begin
                        if (!i_sts.wr_more) n_phase = r_raw ? PH_RDPEND : PH_WAIT;
                        n_cmd.emit = 1'b1;
                        n_cmd.last = 1'b1;
                        n_step = S_IDLE;
                    end
                    n_cmd.ready_res = 1'b0;
                end
            end
            S_START: n_step = S_FINAL;
            S_FINAL: if (!i_sts.busy) begin
                n_cmd.emit = 1'b1;
                n_cmd.last = 1'b1;
                n_cmd.ready_res = (r_phase == PH_READY);
                n_step = S_IDLE;
            end
            default: n_step = S_IDLE;
        endcase
        o_cmd = n_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
            r_phase <= PH_READY;
            r_raw <= 1'b0;
        end else begin
            r_step <= n_step;
            r_phase <= n_phase;
            r_raw <= n_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        r_room <= n_room;
        r_fstat <= n_cmd.status;
        if (accept) begin
            r_item <= i_item;
            r_wr <= (i_item.kind == K_START_WR);
        end
    end

`include "i2c_transfer_sequencer_assert.svh"
    `SEQ_ASSERT_IMP(a_push_only_tx, i_clk, i_rst_n, o_cmd.push, r_step == S_PUSH)
    `SEQ_ASSERT_IMP(a_stall_busy, i_clk, i_rst_n, r_step != S_IDLE, o_stall)
    `SEQ_ASSERT_NEXT(a_fstat_ok, i_clk, i_rst_n, r_step == S_FINAL && !i_sts.busy,
        r_step == S_IDLE && r_fstat == ST_OK)
endmodule

### src/i2c_transfer_sequencer.sv
// I2C transfer sequencer: a command item enters, one or more result items leave.
// Every result passes one output register and is formed only when that register
// is free. A start read or a tick that issues the read start yields a start and
// a status result, a tick in transmit one result per FIFO push and a status,
// and a start write its pushes, a start and a status (at most 16 pushes).
// The input stalls while an item's results are still being produced or the
// output register holds a result not yet taken. Depends on its_pkg.
module i2c_transfer_sequencer import its_pkg::*; #(
    parameter int WRITE_DEPTH = 32,
    parameter int READ_DEPTH  = 32,
    parameter int FIFO_DEPTH  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);
    t_cmd     cmd;
    t_sts     sts;
    t_in_item cur;

    its_ctrl #(.WRITE_DEPTH(WRITE_DEPTH), .READ_DEPTH(READ_DEPTH),
               .FIFO_DEPTH(FIFO_DEPTH)) u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_item,
        .o_item(cur), .i_sts(sts), .o_cmd(cmd)
    );

    its_datapath #(.WRITE_DEPTH(WRITE_DEPTH), .READ_DEPTH(READ_DEPTH)) u_dp (
        .i_clk, .i_rst_n, .i_item(cur), .i_cmd(cmd), .o_sts(sts),
        .o_valid, .i_stall, .o_item
    );
endmodule
